// ----- rtl/tds_pkg.sv -----
// Package with shared constants, types and fixed-point helpers for the tridiagonal solver.
`default_nettype none
package tds_pkg;
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int WORD_W        = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  function automatic word_t sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/tds_div.sv -----
// Shared radix-2 signed fixed-point divider with zero-divisor saturation.
`default_nettype none
module tds_div import tds_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire [32:0] num,
  input  wire [31:0] den,
  output logic       done,
  output logic       zero_div,
  output word_t      quot
);
  localparam int NW = 33 + FRAC_BITS;
  logic [NW-1:0] dvd;
  logic [NW:0]   rem;
  logic [31:0]   dvs;
  logic          neg, busy, nz, npos;
  logic [6:0]    cnt;
  logic [NW:0]   trial;
  logic signed [NW+1:0] sq;

  always_comb begin
    trial = {rem[NW-1:0], dvd[NW-1]} - {{(NW-31){1'b0}}, dvs};
    sq = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      neg  <= num[32] ^ den[31];
      nz   <= num != '0;
      npos <= !num[32];
      zero_div <= den == '0;
      dvs  <= den[31] ? -den : den;
      dvd  <= {(num[32] ? -num : num), {FRAC_BITS{1'b0}}};
      rem  <= '0;
      cnt  <= 7'(NW);
      busy <= 1'b1;
    end else if (busy) begin
      if (cnt != '0) begin
        if (!trial[NW]) rem <= trial;
        else rem <= {rem[NW-1:0], dvd[NW-1]};
        dvd <= {dvd[NW-2:0], !trial[NW]};
        cnt <= cnt - 7'd1;
      end else begin
        busy <= 1'b0;
        done <= 1'b1;
        if (zero_div) quot <= !nz ? '0 : (npos ? 32'sh7fffffff : 32'sh80000000);
        else quot <= sat64(66'(sq));
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tridiagonal_system_solver.sv -----
// Top level: Thomas-algorithm tridiagonal solver with stores and sequencer.
//
// One row arrives per transfer on the s_axis channel; tdata carries sub_diag,
// main_diag, super_diag and rhs_value, tlast marks the final row. Each row after
// the first makes two passes through the one shared radix-2 divider before the
// next row is accepted; the first row of a system needs one pass. After the
// final row the block back-substitutes from the last row to the first, each by
// a memory read, a multiply and a write back, and then streams the n solution
// entries on m_axis one at a time, tlast on the final entry and tuser carrying
// the singular flag. No new row is taken until the whole solution has been
// transferred; a stall on m_axis holds the result.
// Synchronous reset returns the sequencer to idle and clears the row count;
// the stores need no clearing as every entry is written before it is read.
// Row MAX_ROWS of a system is treated as its last row.
`default_nettype none
module tridiagonal_system_solver import tds_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // sub_diag[31:0], main_diag[63:32], super_diag[95:64], rhs_value[127:96]
  input  wire  [127:0] s_axis_tdata,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // solution[31:0]
  output logic [31:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // singular[0]
  output logic         m_axis_tuser
);
  localparam int AW = $clog2(MAX_ROWS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DIV1 = 9'b000000010, S_MUL = 9'b000000100,
    S_DIV2 = 9'b000001000, S_BRD = 9'b000010000, S_BMUL = 9'b000100000,
    S_BWR  = 9'b001000000, S_ORD = 9'b010000000, S_OUT = 9'b100000000
  } state_t;
  state_t state;

  word_t gamma_mem [MAX_ROWS];
  word_t part_mem  [MAX_ROWS];
  word_t g_rd, p_rd;
  logic [AW-1:0] wa, ra;
  logic we_g, we_p;
  word_t wd_g, wd_p;

  always_ff @(posedge clk) begin
    if (we_g) gamma_mem[wa] <= wd_g;
    if (we_p) part_mem[wa] <= wd_p;
    g_rd <= gamma_mem[ra];
    p_rd <= part_mem[ra];
  end

  word_t a, b, r, psuper, ppivot, ppart, gam, piv, u;
  logic [AW-1:0] row, idx, nlast;
  logic last_f, sing;
  logic dstart, ddone, dzero;
  logic [32:0] dnum;
  word_t dden, dq;
  logic signed [63:0] prod;

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .zero_div(dzero), .quot(dq)
  );

  function automatic word_t qround(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + (66'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    return sat64(t);
  endfunction

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tdata = u;
  assign m_axis_tuser = sing;

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    we_g <= 1'b0;
    we_p <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      row <= '0;
      sing <= 1'b0;
      psuper <= '0;
      ppivot <= '0;
      ppart <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          a <= s_axis_tdata[31:0];
          b <= s_axis_tdata[63:32];
          r <= s_axis_tdata[127:96];
          psuper <= s_axis_tdata[95:64];
          last_f <= s_axis_tlast || (32'(row) + 32'd1 >= 32'(MAX_ROWS));
          if (row == '0) begin
            gam <= '0;
            piv <= s_axis_tdata[63:32];
            dnum <= {s_axis_tdata[127], s_axis_tdata[127:96]};
            dden <= s_axis_tdata[63:32];
            dstart <= 1'b1;
            state <= S_DIV2;
          end else begin
            dnum <= {psuper[31], psuper};
            dden <= ppivot;
            dstart <= 1'b1;
            state <= S_DIV1;
          end
        end
        S_DIV1: if (ddone) begin
          gam <= dq;
          if (dzero) sing <= 1'b1;
          prod <= a * dq;
          state <= S_MUL;
        end
        S_MUL: begin
          piv <= sat64(66'(b) - 66'(qround(prod)));
          dnum <= 33'(66'(r) - 66'(qround(a * ppart)));
          dden <= sat64(66'(b) - 66'(qround(prod)));
          dstart <= 1'b1;
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (ddone) begin
            if (dzero) sing <= 1'b1;
            wa <= row;
            wd_g <= gam;
            wd_p <= dq;
            we_g <= 1'b1;
            we_p <= 1'b1;
            ppivot <= piv;
            ppart <= dq;
            if (last_f) begin
              nlast <= row;
              idx <= row;
              u <= dq;
              state <= (row == '0) ? S_ORD : S_BRD;
              ra <= row;
            end else begin
              row <= row + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_BRD: begin
          ra <= idx - 1'b1;
          state <= S_BMUL;
        end
        S_BMUL: begin
          prod <= ((idx == nlast) ? gam : g_rd) * u;
          idx <= idx - 1'b1;
          state <= S_BWR;
        end
        S_BWR: begin
          u <= sat64(66'(p_rd) - 66'(qround(prod)));
          wa <= idx;
          wd_p <= sat64(66'(p_rd) - 66'(qround(prod)));
          we_p <= 1'b1;
          state <= (idx == '0) ? S_ORD : S_BRD;
          ra <= idx;
        end
        S_ORD: begin
          if (!we_p && !m_axis_tvalid) begin
            ra <= idx;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            u <= p_rd;
            m_axis_tvalid <= 1'b1;
            m_axis_tlast <= idx == nlast;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              state <= S_IDLE;
              row <= '0;
              sing <= 1'b0;
              psuper <= '0;
              ppivot <= '0;
              ppart <= '0;
            end else begin
              idx <= idx + 1'b1;
              ra <= idx + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while output pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
endmodule
`default_nettype wire
